@@ hw/rtl/tcc_pkg.sv @@
`timescale 1ns / 1ps

package tcc_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Fixed field widths of the channels and the register port.
   localparam int FUNC_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = 11;
   localparam int WORD_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int COLOR_W   = 4;
   localparam int CSR_IDX_W = 1;

   // Item function codes.
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FG_COLOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BG_COLOR = 1'b1;

   // Register reset values.
   localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // Tab stops fall on multiples of this.
   localparam int TAB_STEP = 8;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_TAKE,
      OP_PUT,
      OP_READ,
      OP_INIT,
      OP_CLEAR,
      OP_COPY,
      OP_BLANK
   } dp_op_type;

   // Controller to datapath.
   typedef struct packed {
      dp_op_type op;
      logic      load_out;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              scroll_due;
      logic              sweep_last;
      logic              out_free;
   } sts_type;

endpackage

@@ hw/rtl/tcc_channels.sv @@
`timescale 1ns / 1ps

// Request channel: one console item.
interface tcc_req_if
   import tcc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CHAR_W-1:0] char_code;
   logic [IDX_W-1:0]  cell_index;

   modport source (output valid, func, char_code, cell_index, input ready);
   modport sink   (input valid, func, char_code, cell_index, output ready);
endinterface

// Response channel: one result item.
interface tcc_rsp_if
   import tcc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    cell_word;
   logic [ROW_OUT_W-1:0] cursor_row;
   logic [COL_OUT_W-1:0] cursor_col;
   logic                 scrolled;

   modport source (output valid, cell_word, cursor_row, cursor_col, scrolled, input ready);
   modport sink   (input valid, cell_word, cursor_row, cursor_col, scrolled, output ready);
endinterface

@@ hw/rtl/tcc_ctrl.sv @@
`timescale 1ns / 1ps

module tcc_ctrl
   import tcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_COPY,
      S_BLANK,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath command for the current state.
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.load_out = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.op = OP_INIT;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_TAKE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.func)
               FUNC_PUT: begin
                  cmd.op = OP_PUT;
                  if (sts.scroll_due) begin
                     state_in = S_COPY;
                  end else if (sts.out_free) begin
                     cmd.load_out = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               FUNC_CLEAR: begin
                  state_in = S_CLEAR;
               end
               FUNC_READ: begin
                  cmd.op   = OP_READ;
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            cmd.op = OP_COPY;
            if (sts.sweep_last) begin
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            cmd.op = OP_BLANK;
            if (sts.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/tcc_dp.sv @@
`timescale 1ns / 1ps

module tcc_dp
   import tcc_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [IDX_W-1:0]     req_cell_index,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_cell_word,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [COL_OUT_W-1:0] rsp_cursor_col,
   output logic                 rsp_scrolled
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int CLW   = $clog2(COLUMNS);
   localparam int CXW   = $clog2(COLUMNS + TAB_STEP);

   localparam logic [AW-1:0]  CELLS_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0]  COPY_LAST  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0]  LINE_LAST  = AW'(COLUMNS - 1);
   localparam logic [AW-1:0]  LINE_BASE  = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0]  COLS_A     = AW'(COLUMNS);
   localparam logic [RW-1:0]  ROWS_R     = RW'(ROWS);
   localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
   localparam logic [CXW-1:0] COLS_X     = CXW'(COLUMNS);
   localparam logic [CXW-1:0] TAB_ADD    = CXW'(TAB_STEP);
   localparam logic [CXW-1:0] TAB_MASK   = ~CXW'(TAB_STEP - 1);

   // Screen store.
   logic [WORD_W-1:0] cells_ff [CELLS];
   logic [WORD_W-1:0] rd_data_ff;

   // Item, cursor, colours and sweep counter.
   logic [FUNC_W-1:0]  func_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               idx_ok_ff;
   logic [RW-1:0]      row_ff, row_in;
   logic [CLW-1:0]     col_ff, col_in;
   logic               scrolled_ff, scrolled_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [COLOR_W-1:0] fg_ff, bg_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    out_word_ff;
   logic [ROW_OUT_W-1:0] out_row_ff;
   logic [COL_OUT_W-1:0] out_col_ff;
   logic                 out_scr_ff;

   logic              wr_en, rd_en, sweep_last;
   logic [AW-1:0]     wr_addr, rd_addr, cur_addr;
   logic [WORD_W-1:0] wr_data, blank_word;
   logic [RW-1:0]     put_row;
   logic [CLW-1:0]    put_col;
   logic              put_write;
   logic [CXW-1:0]    col_inc, tab_sum;

   assign blank_word = {bg_ff, fg_ff, CHAR_SPACE};
   assign cur_addr   = AW'(32'(row_ff) * 32'(COLUMNS) + 32'(col_ff));
   assign col_inc    = CXW'(col_ff) + CXW'(1);
   assign tab_sum    = (CXW'(col_ff) + TAB_ADD) & TAB_MASK;

   // Cursor movement for a put item.
   always_comb begin
      put_row   = row_ff;
      put_col   = col_ff;
      put_write = 1'b0;
      priority if (char_ff == CHAR_LF) begin
         put_col = '0;
         put_row = row_ff + RW'(1);
      end else if (char_ff == CHAR_CR) begin
         put_col = '0;
      end else if (char_ff == CHAR_TAB) begin
         if (tab_sum >= COLS_X) begin
            put_col = '0;
            put_row = row_ff + RW'(1);
         end else begin
            put_col = CLW'(tab_sum);
         end
      end else if (char_ff >= CHAR_SPACE) begin
         put_write = 1'b1;
         if (col_inc >= COLS_X) begin
            put_col = '0;
            put_row = row_ff + RW'(1);
         end else begin
            put_col = CLW'(col_inc);
         end
      end else begin
         put_write = 1'b0;
      end
   end

   // Store ports, sweep counter and cursor update per operation.
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      scrolled_in = scrolled_ff;
      cnt_in      = '0;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff + COLS_A;
      sweep_last  = 1'b0;
      unique case (cmd.op)
         OP_TAKE: begin
            scrolled_in = 1'b0;
         end
         OP_PUT: begin
            row_in  = put_row;
            col_in  = put_col;
            wr_en   = put_write;
            wr_addr = cur_addr;
            wr_data = {bg_ff, fg_ff, char_ff};
         end
         OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = AW'(32'(idx_ff));
         end
         OP_INIT: begin
            wr_en      = 1'b1;
            sweep_last = (cnt_ff == CELLS_LAST);
            cnt_in     = sweep_last ? '0 : cnt_ff + AW'(1);
         end
         OP_CLEAR: begin
            wr_en      = 1'b1;
            wr_data    = blank_word;
            sweep_last = (cnt_ff == CELLS_LAST);
            cnt_in     = sweep_last ? '0 : cnt_ff + AW'(1);
            if (sweep_last) begin
               row_in = '0;
               col_in = '0;
            end
         end
         OP_COPY: begin
            // Read one line further down, write the word read in the cycle before.
            rd_en      = 1'b1;
            wr_en      = (cnt_ff != '0);
            wr_addr    = cnt_ff - AW'(1);
            wr_data    = rd_data_ff;
            sweep_last = (cnt_ff == COPY_LAST);
            cnt_in     = sweep_last ? '0 : cnt_ff + AW'(1);
         end
         OP_BLANK: begin
            wr_en      = 1'b1;
            wr_addr    = LINE_BASE + cnt_ff;
            wr_data    = blank_word;
            sweep_last = (cnt_ff == LINE_LAST);
            cnt_in     = sweep_last ? '0 : cnt_ff + AW'(1);
            if (sweep_last) begin
               row_in      = LAST_ROW;
               scrolled_in = 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Screen store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_TAKE) begin
         func_ff <= req_func;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      if (cmd.op == OP_READ) begin
         idx_ok_ff <= (32'(idx_ff) < 32'(CELLS));
      end
   end

   // Control state: cursor, sweep counter, colours and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         scrolled_ff  <= 1'b0;
         cnt_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         scrolled_ff <= scrolled_in;
         cnt_ff      <= cnt_in;
         if (csr_we && csr_index == REG_FG_COLOR) begin
            fg_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_BG_COLOR) begin
            bg_ff <= csr_wdata;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, taken from the values the cursor is about to hold.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_word_ff <= (func_ff == FUNC_READ && idx_ok_ff) ? rd_data_ff : '0;
         out_row_ff  <= ROW_OUT_W'(32'(row_in));
         out_col_ff  <= COL_OUT_W'(32'(col_in));
         out_scr_ff  <= scrolled_in;
      end
   end

   assign sts.func       = func_ff;
   assign sts.scroll_due = (put_row == ROWS_R);
   assign sts.sweep_last = sweep_last;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_word  = out_word_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_scrolled   = out_scr_ff;

endmodule

@@ hw/rtl/text_console_cursor_writer.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Handshake        Payload
// req_ch     in         valid / ready    func, char_code, cell_index
// rsp_ch     out        valid / ready    cell_word, cursor_row, cursor_col, scrolled
// csr_*      in         csr_we           csr_index, csr_wdata (fg_color, bg_color)
//
// A put item is taken and then executed; a read item adds a store read before its result is loaded.
// A put that passes the last row adds a line copy, a bottom-line blanking and a step to load
// the result; a clear sweeps every cell with blanks and homes the cursor, then loads its result.
// After reset a clearing pass zeroes the store before the first item is taken.
// Results sit in an output register, so a new item is accepted while the previous result
// waits; the block stalls only when it must load a second.

module text_console_cursor_writer
   import tcc_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   tcc_req_if.sink              req_ch,
   tcc_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Screen store, cursor and result register.
   tcc_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_ch.func),
      .req_char_code  (req_ch.char_code),
      .req_cell_index (req_ch.cell_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_cell_word  (rsp_ch.cell_word),
      .rsp_cursor_row (rsp_ch.cursor_row),
      .rsp_cursor_col (rsp_ch.cursor_col),
      .rsp_scrolled   (rsp_ch.scrolled)
   );

endmodule
